// ===== rtl/fgpid_pkg.sv =====
// Shared constants for the fuzzy gain-scheduled PID controller: fixed-point
// limits, register indexes and the base fuzzy rule table.
// Depends on nothing; imported by fuzzy_gain_scheduled_pid.
package fgpid_pkg;

	// default number of triangular sets per input
	localparam int FUZZY_SETS_DEF = 7;

	// fuzzy universe edge (3.0 in Q16) and unit membership
	localparam logic [17:0] UNI_EDGE = 18'd196608;
	localparam logic [16:0] MU_ONE = 17'd65536;
	// smallest membership that counts (first Q16 value above 1e-4)
	localparam logic [16:0] MU_FLOOR = 17'd7;
	// ceil(2^19 / 3): exact m/3 for m below 2^19
	localparam logic [17:0] RECIP3 = 18'd174763;

	// integral and output saturation bounds
	localparam logic signed [55:0] INT48_MAX = 56'sd140737488355327;
	localparam logic signed [55:0] INT48_MIN = -56'sd140737488355328;
	localparam logic signed [55:0] INT32_MAX = 56'sd2147483647;
	localparam logic signed [55:0] INT32_MIN = -56'sd2147483648;

	// configuration register indexes
	localparam logic [2:0] REG_KP_GAIN = 3'd0;
	localparam logic [2:0] REG_KI_GAIN = 3'd1;
	localparam logic [2:0] REG_KD_GAIN = 3'd2;
	localparam logic [2:0] REG_KP_ADJ_MAX = 3'd3;
	localparam logic [2:0] REG_KI_ADJ_MAX = 3'd4;
	localparam logic [2:0] REG_KD_ADJ_MAX = 3'd5;
	localparam logic [2:0] REG_ERR_FS = 3'd6;
	localparam logic [2:0] REG_DERR_FS = 3'd7;

	// base rules for kp, ki and kd; row is the error set, column the change set
	localparam logic signed [2:0] BASE_RULES [0:2][0:6][0:6] = '{
		'{
			'{3, 3, 2, 2, 1, 0, 0}, '{3, 3, 2, 1, 1, 0, -1},
			'{2, 2, 2, 1, 0, -1, -1}, '{2, 2, 1, 0, -1, -2, -2},
			'{1, 1, 0, -1, -1, -2, -2}, '{1, 0, -1, -2, -2, -2, -3},
			'{0, 0, -2, -2, -2, -3, -3}
		},
		'{
			'{-3, -3, -2, -2, -1, 0, 0}, '{-3, -3, -2, -1, -1, 0, 0},
			'{-3, -2, -1, -1, 0, 1, 1}, '{-2, -2, -1, 0, 1, 2, 2},
			'{-2, -1, 0, 1, 1, 2, 3}, '{0, 0, 1, 1, 2, 3, 3},
			'{0, 0, 1, 2, 2, 3, 3}
		},
		'{
			'{1, -1, -3, -3, -3, -2, 1}, '{1, -1, -3, -2, -2, -1, 0},
			'{0, -1, -2, -2, -1, -1, 0}, '{0, -1, -1, -1, -1, -1, 0},
			'{0, 0, 0, 0, 0, 0, 0}, '{3, 1, 1, 1, 1, 1, 3},
			'{3, 2, 2, 2, 1, 1, 3}
		}
	};

endpackage

// ===== rtl/fuzzy_gain_scheduled_pid.sv =====
// Fuzzy gain-scheduled PID controller, top level.
// Depends on fgpid_pkg for constants, register indexes and the rule table.
//
// One sample pair in, one saturated Q16.16 drive word out. The block works on
// one word at a time and is not ready while it does. A shared restoring divider
// and a shared 34x21 multiplier do all the arithmetic under a small sequencer.
// An item passes through accept, scaling of the error and its change by two
// divides, fuzzification, rule evaluation over every set pair, a multiply and
// divide per enabled gain adjustment (skipped when disabled or no rule fires),
// the three PID products, the sum and the output, where it waits while the
// output word is not taken; most of the time goes to the divider.
module fuzzy_gain_scheduled_pid #(
	parameter int FUZZY_SETS = fgpid_pkg::FUZZY_SETS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// sample input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] measured_value, [31:16] target_value
	// drive output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [31:0] control_value
);
	import fgpid_pkg::*;

	localparam int SW = $clog2(FUZZY_SETS);
	localparam logic [SW-1:0] LAST_SET = SW'(FUZZY_SETS - 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DIV_E   = 4'd1;
	localparam logic [3:0] ST_DIV_D   = 4'd2;
	localparam logic [3:0] ST_MU      = 4'd3;
	localparam logic [3:0] ST_PAIR    = 4'd4;
	localparam logic [3:0] ST_ADJ_MUL = 4'd5;
	localparam logic [3:0] ST_ADJ_LD  = 4'd6;
	localparam logic [3:0] ST_ADJ_DIV = 4'd7;
	localparam logic [3:0] ST_P       = 4'd8;
	localparam logic [3:0] ST_I       = 4'd9;
	localparam logic [3:0] ST_D       = 4'd10;
	localparam logic [3:0] ST_SUM     = 4'd11;
	localparam logic [3:0] ST_OUT     = 4'd12;

	localparam logic [5:0] DIV_LAST = 6'd35;

	// control and state registers
	logic [3:0]          state_q;
	logic [5:0]          cnt_q;
	logic [SW-1:0]       idx_q;
	logic                sel_q;
	logic                ph_q;
	logic [SW-1:0]       pi_q;
	logic [SW-1:0]       pj_q;
	logic                feed_q;
	logic                pv_s1;
	logic [1:0]          k_q;
	logic                ovalid_q;
	logic signed [16:0]  prev_q;
	logic signed [47:0]  integ_q;
	logic [31:0]         kp_q, ki_q, kd_q, kpam_q, kiam_q, kdam_q;
	logic [15:0]         efs_q, dfs_q;

	// datapath registers
	logic signed [16:0]  e_q;
	logic signed [17:0]  de_q;
	logic signed [18:0]  xe_q, xd_q;
	logic [19:0]         rem_q;
	logic [35:0]         dvd_q;
	logic [19:0]         dsr_q;
	logic [16:0]         mue_q [FUZZY_SETS];
	logic [16:0]         mud_q [FUZZY_SETS];
	logic [SW-1:0]       ri_s1, rj_s1;
	logic [17:0]         den_q;
	logic signed [20:0]  num_q [3];
	logic signed [33:0]  dk_q [3];
	logic signed [54:0]  pterm_q;
	logic signed [31:0]  res_q;
	logic [31:0]         odata_q;
	logic signed [54:0]  prod_q;

	// set centres and rule row/column map, fixed at elaboration
	logic signed [19:0]  centre [FUZZY_SETS];
	logic [2:0]          rmap [FUZZY_SETS];

	for (genvar gi = 0; gi < FUZZY_SETS; gi++) begin : g_set
		localparam int CT = (gi * 6 * 65536) / (FUZZY_SETS - 1) - 196608;
		localparam int RM = (gi * 6 + (FUZZY_SETS - 1) / 2) / (FUZZY_SETS - 1);
		assign centre[gi] = 20'(CT);
		assign rmap[gi] = 3'(RM);
	end

	// error and its change from the incoming word
	logic signed [16:0] e_in;
	logic signed [17:0] de_in;
	logic [16:0]        e_abs;
	logic [17:0]        de_abs;
	logic [51:0]        dvd_e, dvd_d;
	logic [19:0]        sc_e, sc_d;
	logic               in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign e_in = 17'($signed(s_axis_tdata[31:16])) - 17'($signed(s_axis_tdata[15:0]));
	assign de_in = 18'(e_in) - 18'(prev_q);
	assign e_abs = e_in[16] ? 17'(-e_in) : 17'(e_in);
	assign de_abs = de_q[17] ? 18'(-de_q) : 18'(de_q);
	// |v| * 3.0 in Q16
	assign dvd_e = (52'(e_abs) + 52'({e_abs, 1'b0})) << 16;
	assign dvd_d = (52'(de_abs) + 52'({de_abs, 1'b0})) << 16;
	assign sc_e = (efs_q == 16'd0) ? 20'd1 : 20'(efs_q);
	assign sc_d = (dfs_q == 16'd0) ? 20'd1 : 20'(dfs_q);

	// one restoring divide step
	logic [20:0] shl;
	logic        ge;
	logic [20:0] diff;
	logic [19:0] rem_nx;
	logic [35:0] quo_nx;

	assign shl = {rem_q, dvd_q[35]};
	assign ge = shl >= {1'b0, dsr_q};
	assign diff = shl - {1'b0, dsr_q};
	assign rem_nx = ge ? diff[19:0] : shl[19:0];
	assign quo_nx = {dvd_q[34:0], ge};

	// clamp a scaled value to the universe edge and restore its sign
	logic [17:0]        umag;
	logic               xneg;
	logic signed [18:0] xval;

	assign umag = (quo_nx > 36'(UNI_EDGE)) ? UNI_EDGE : quo_nx[17:0];
	assign xneg = (state_q == ST_DIV_E) ? e_q[16] : de_q[17];
	assign xval = xneg ? -$signed({1'b0, umag}) : $signed({1'b0, umag});

	// triangular membership of the current set
	logic signed [19:0] cdiff;
	logic [18:0]        dabs;
	logic [22:0]        nval;
	logic               over;
	logic [17:0]        mhalf;
	logic [16:0]        mu_raw;
	logic [16:0]        mu_val;

	assign cdiff = 20'(sel_q ? xd_q : xe_q) - centre[idx_q];
	assign dabs = cdiff[19] ? 19'(-cdiff) : 19'(cdiff);
	assign nval = 23'(dabs) * 23'(FUZZY_SETS - 1);
	assign over = nval >= 23'(2 * UNI_EDGE);
	assign mhalf = nval[18:1];
	assign mu_raw = MU_ONE - 17'(prod_q[35:19]);
	assign mu_val = (over || mu_raw < MU_FLOOR) ? 17'd0 : mu_raw;

	// pair weight and rule contributions
	logic [33:0]        wsum;
	logic [17:0]        wgt;
	logic signed [20:0] wterm [3];

	assign wsum = 34'(prod_q[32:0]) + 34'd32768;
	assign wgt = wsum[33:16];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wterm[k] = 21'($signed({3'b000, wgt}) *
				21'(BASE_RULES[k][rmap[ri_s1]][rmap[rj_s1]]));
		end
	end

	// gain adjustment operands
	logic               adj_en;
	logic [31:0]        maxv;
	logic signed [20:0] numk;
	logic [20:0]        numk_abs;

	assign adj_en = (den_q != 18'd0) && ((k_q == 2'd0) ||
		((ki_q != 32'd0) && ((k_q == 2'd1) || (kd_q != 32'd0))));
	assign numk = num_q[k_q];
	assign numk_abs = numk[20] ? 21'(-numk) : 21'(numk);
	always_comb begin
		case (k_q)
			2'd0: maxv = kpam_q;
			2'd1: maxv = kiam_q;
			default: maxv = kdam_q;
		endcase
	end

	// shared multiplier operand select
	logic signed [33:0] mul_a;
	logic signed [20:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MU: begin
				mul_a = $signed(34'(mhalf));
				mul_b = $signed(21'(RECIP3));
			end
			ST_PAIR: begin
				mul_a = $signed(34'(mue_q[pi_q]));
				mul_b = $signed(21'(mud_q[pj_q]));
			end
			ST_ADJ_MUL: begin
				mul_a = $signed(34'(maxv));
				mul_b = $signed(numk_abs);
			end
			ST_P: begin
				mul_a = $signed(34'(kp_q)) + dk_q[0];
				mul_b = 21'(e_q);
			end
			ST_I: begin
				mul_a = $signed(34'(ki_q)) + dk_q[1];
				mul_b = 21'(e_q);
			end
			ST_D: begin
				mul_a = $signed(34'(kd_q)) + dk_q[2];
				mul_b = 21'(de_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// integral and output saturation
	logic signed [55:0] integ_raw;
	logic signed [47:0] integ_sat;
	logic signed [55:0] sum_raw;
	logic signed [31:0] sum_sat;
	logic               out_load;

	assign integ_raw = 56'(integ_q) + 56'(prod_q);
	assign integ_sat = (integ_raw > INT48_MAX) ? 48'(INT48_MAX) :
		(integ_raw < INT48_MIN) ? 48'(INT48_MIN) : integ_raw[47:0];
	assign sum_raw = 56'(pterm_q) + 56'(integ_q) + 56'(prod_q);
	assign sum_sat = (sum_raw > INT32_MAX) ? 32'(INT32_MAX) :
		(sum_raw < INT32_MIN) ? 32'(INT32_MIN) : sum_raw[31:0];
	assign out_load = (state_q == ST_OUT) && (!ovalid_q || m_axis_tready);

	// sequencer, configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			sel_q <= 1'b0;
			ph_q <= 1'b0;
			pi_q <= '0;
			pj_q <= '0;
			feed_q <= 1'b0;
			pv_s1 <= 1'b0;
			k_q <= '0;
			ovalid_q <= 1'b0;
			prev_q <= '0;
			integ_q <= '0;
			kp_q <= 32'd152917;
			ki_q <= 32'd655;
			kd_q <= 32'd0;
			kpam_q <= 32'd152917;
			kiam_q <= 32'd655;
			kdam_q <= 32'd0;
			efs_q <= 16'd100;
			dfs_q <= 16'd100;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_KP_GAIN: kp_q <= cfg_data;
					REG_KI_GAIN: ki_q <= cfg_data;
					REG_KD_GAIN: kd_q <= cfg_data;
					REG_KP_ADJ_MAX: kpam_q <= cfg_data;
					REG_KI_ADJ_MAX: kiam_q <= cfg_data;
					REG_KD_ADJ_MAX: kdam_q <= cfg_data;
					REG_ERR_FS: efs_q <= cfg_data[15:0];
					REG_DERR_FS: dfs_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			// drop the output word once taken
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end

			pv_s1 <= (state_q == ST_PAIR) && feed_q;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						state_q <= ST_DIV_E;
					end
				end
				ST_DIV_E: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						cnt_q <= '0;
						state_q <= ST_DIV_D;
					end
				end
				ST_DIV_D: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						idx_q <= '0;
						sel_q <= 1'b0;
						ph_q <= 1'b0;
						state_q <= ST_MU;
					end
				end
				ST_MU: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						sel_q <= !sel_q;
						if (sel_q) begin
							if (idx_q == LAST_SET) begin
								pi_q <= '0;
								pj_q <= '0;
								feed_q <= 1'b1;
								state_q <= ST_PAIR;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end
				end
				ST_PAIR: begin
					// advance over every pair, then wait for the last sum
					if (feed_q) begin
						if (pj_q == LAST_SET) begin
							pj_q <= '0;
							if (pi_q == LAST_SET) begin
								feed_q <= 1'b0;
							end else begin
								pi_q <= pi_q + 1'b1;
							end
						end else begin
							pj_q <= pj_q + 1'b1;
						end
					end else if (!pv_s1) begin
						k_q <= '0;
						state_q <= ST_ADJ_MUL;
					end
				end
				ST_ADJ_MUL: begin
					if (adj_en) begin
						state_q <= ST_ADJ_LD;
					end else if (k_q == 2'd2) begin
						state_q <= ST_P;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_ADJ_LD: begin
					cnt_q <= '0;
					state_q <= ST_ADJ_DIV;
				end
				ST_ADJ_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						if (k_q == 2'd2) begin
							state_q <= ST_P;
						end else begin
							k_q <= k_q + 2'd1;
							state_q <= ST_ADJ_MUL;
						end
					end
				end
				ST_P: state_q <= ST_I;
				ST_I: state_q <= ST_D;
				ST_D: state_q <= ST_SUM;
				ST_SUM: begin
					// hold the integral, keep this error for the next change
					integ_q <= integ_q;
					prev_q <= e_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// accumulate the integral when the ki product lands
			if (state_q == ST_D) begin
				integ_q <= integ_sat;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		ri_s1 <= pi_q;
		rj_s1 <= pj_q;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					e_q <= e_in;
					de_q <= de_in;
					rem_q <= 20'(dvd_e[51:36]);
					dvd_q <= dvd_e[35:0];
					dsr_q <= sc_e;
				end
			end
			ST_DIV_E: begin
				rem_q <= rem_nx;
				dvd_q <= quo_nx;
				if (cnt_q == DIV_LAST) begin
					xe_q <= xval;
					rem_q <= 20'(dvd_d[51:36]);
					dvd_q <= dvd_d[35:0];
					dsr_q <= sc_d;
				end
			end
			ST_DIV_D: begin
				rem_q <= rem_nx;
				dvd_q <= quo_nx;
				if (cnt_q == DIV_LAST) begin
					xd_q <= xval;
				end
			end
			ST_MU: begin
				if (ph_q) begin
					if (sel_q) begin
						mud_q[idx_q] <= mu_val;
					end else begin
						mue_q[idx_q] <= mu_val;
					end
				end
				den_q <= '0;
				for (int k = 0; k < 3; k++) begin
					num_q[k] <= '0;
				end
			end
			ST_PAIR: begin
				if (pv_s1) begin
					den_q <= den_q + wgt;
					for (int k = 0; k < 3; k++) begin
						num_q[k] <= num_q[k] + wterm[k];
					end
				end
			end
			ST_ADJ_MUL: begin
				if (!adj_en) begin
					dk_q[k_q] <= '0;
				end
			end
			ST_ADJ_LD: begin
				rem_q <= 20'(prod_q[51:36]);
				dvd_q <= prod_q[35:0];
				dsr_q <= 20'({den_q, 1'b0}) + 20'(den_q);
			end
			ST_ADJ_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= quo_nx;
				if (cnt_q == DIV_LAST) begin
					dk_q[k_q] <= numk[20] ? -$signed(34'(quo_nx[31:0])) :
						$signed(34'(quo_nx[31:0]));
				end
			end
			ST_I: pterm_q <= prod_q;
			ST_SUM: res_q <= sum_sat;
			ST_OUT: begin
				if (out_load) begin
					odata_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;

`ifndef SYNTHESIS
	// an accepted word starts the error scaling at once
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_DIV_E)
		else $error("accepted word did not start scaling");

	// a finished result reaches the output and frees the input side
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid && s_axis_tready)
		else $error("result not delivered");

	// the adjustment counter stays on the three gains
	a_kidx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADJ_MUL || state_q == ST_ADJ_DIV) |-> k_q != 2'd3)
		else $error("gain index out of range");

	// set index stays within the configured sets
	a_mu_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MU |-> idx_q <= LAST_SET)
		else $error("set index out of range");
`endif

endmodule
